@@ hw/rtl/parallel_eeprom_program_sequencer_top_defines.svh @@
// assertion macros for the eeprom program sequencer
`ifndef PARALLEL_EEPROM_PROGRAM_SEQUENCER_TOP_DEFINES_SVH
`define PARALLEL_EEPROM_PROGRAM_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PEP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pep assertion failed");

// next-cycle implication
`define PEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pep assertion failed");

`else

`define PEP_ASSERT_IMP(label, clk, rst, ante, cons)
`define PEP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/pep_pkg.sv @@
// shared types, constants and tables of the eeprom program sequencer
`default_nettype none

package pep_pkg;

   localparam int PAGE_SHIFT_DEFAULT  = 6;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int ACTION_W    = 3;
   localparam int ADDR_W      = 15;
   localparam int BUS_ADDR_W  = 16;
   localparam int DATA_W      = 8;
   localparam int LEN_W       = 7;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int POLL_W      = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int STEP_W      = 3;
   localparam int UNLOCK_LEN  = 6;

   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 17'd100000;

   // command codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_OPEN   = 3'd0,
      ACT_CLOSE  = 3'd1,
      ACT_ERASE  = 3'd2,
      ACT_WRITE  = 3'd3,
      ACT_VERIFY = 3'd4,
      ACT_RETURN = 3'd5
   } action_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_READ   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_PAGE       = 3'd1,
      ST_POLL_MIS   = 3'd2,
      ST_TIMEOUT    = 3'd3,
      ST_NO_SESSION = 3'd4,
      ST_VERIFY_MIS = 3'd5
   } status_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_POLL   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_A15 = 1'd1;

   // work handed from front to back
   typedef enum logic [2:0] {
      JOB_STATUS     = 3'd0,
      JOB_READ       = 3'd1,
      JOB_WRITE      = 3'd2,
      JOB_WRITE_READ = 3'd3,
      JOB_ERASE      = 3'd4
   } job_kind_type;

   typedef struct packed {
      job_kind_type            kind;
      logic [BUS_ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]       data;
      status_type              status;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [POLL_W-1:0] max_poll;
      logic              select_a15;
   } cfg_type;

   typedef struct packed {
      kind_type              kind;
      logic [BUS_ADDR_W-1:0] bus_address;
      logic [DATA_W-1:0]     bus_data;
      status_type            status;
      logic                  last;
   } rsp_item_type;

   // chip erase unlock sequence
   function automatic logic [ADDR_W-1:0] unlock_addr(input logic [STEP_W-1:0] step);
      logic [ADDR_W-1:0] a;
      case (step)
         3'd0:    a = 15'h5555;
         3'd1:    a = 15'h2aaa;
         3'd2:    a = 15'h5555;
         3'd3:    a = 15'h5555;
         3'd4:    a = 15'h2aaa;
         3'd5:    a = 15'h5555;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic [DATA_W-1:0] unlock_data(input logic [STEP_W-1:0] step);
      logic [DATA_W-1:0] d;
      case (step)
         3'd0:    d = 8'haa;
         3'd1:    d = 8'h55;
         3'd2:    d = 8'h80;
         3'd3:    d = 8'haa;
         3'd4:    d = 8'h55;
         3'd5:    d = 8'h10;
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pep_channel_if.sv @@
// channel interfaces: command input, result output, configuration writes
`default_nettype none

interface pep_req_if import pep_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   data_byte;
   logic [LEN_W-1:0]    run_length;
   logic                first_of_run;
   logic                last_of_run;
   logic [DATA_W-1:0]   read_data;

   modport source (output valid, action, address, data_byte, run_length,
                   first_of_run, last_of_run, read_data, input ready);
   modport sink   (input valid, action, address, data_byte, run_length,
                   first_of_run, last_of_run, read_data, output ready);
endinterface

interface pep_rsp_if import pep_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [BUS_ADDR_W-1:0] bus_address;
   logic [DATA_W-1:0]     bus_data;
   logic [STATUS_W-1:0]   status;
   logic                  last;

   modport source (output valid, kind, bus_address, bus_data, status, last,
                   input ready);
   modport sink   (input valid, kind, bus_address, bus_data, status, last,
                   output ready);
endinterface

interface pep_csr_if import pep_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/parallel_eeprom_program_sequencer_top.sv @@
// top level of the parallel eeprom program sequencer
//
// req_ch carries commands (open, close, erase, write byte, verify byte) and
// the bytes the chip returns for bus reads; rsp_ch carries bus write
// cycles, bus read requests and status reports, with last set on the final
// result of each command; csr_ch writes the poll limit (index 0) and the
// chip select level on address bit 15 (index 1), always ready.
// a front end decodes each command and pushes at most one job into a
// four-entry queue; a back end expands the job into results through an
// output register. one command is accepted per cycle while the queue has
// room; its job is registered in the queue, then its first result in the
// output register. a job emits one result per cycle while rsp_ch is ready:
// one for most commands, two for the last byte of a write run, seven for a
// chip erase, which sets the sustained rate then.
// when rsp_ch stalls, the output register holds its result and the queue
// fills, after which req_ch.ready drops. reset clears the session, the run
// state, the queue and the output; registers return to poll limit 100000
// and select level 0.
`default_nettype none
`include "parallel_eeprom_program_sequencer_top_defines.svh"

module parallel_eeprom_program_sequencer_top import pep_pkg::*; #(
   parameter int PAGE_SHIFT  = PAGE_SHIFT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   pep_req_if.sink   req_ch,
   pep_rsp_if.source rsp_ch,
   pep_csr_if.sink   csr_ch
);

   cfg_type          cfg_ff;
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_status_type q_status;
   logic             out_valid;
   rsp_item_type     out_item;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_poll   <= POLL_LIMIT_RESET;
         cfg_ff.select_a15 <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MAX_POLL:   cfg_ff.max_poll   <= csr_ch.data[POLL_W-1:0];
            CSR_SELECT_A15: cfg_ff.select_a15 <= csr_ch.data[0];
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   pep_front #(
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   pep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   pep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (out_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (out_item)
   );

   // result channel
   assign rsp_ch.valid       = out_valid;
   assign rsp_ch.kind        = out_item.kind;
   assign rsp_ch.bus_address = out_item.bus_address;
   assign rsp_ch.bus_data    = out_item.bus_data;
   assign rsp_ch.status      = out_item.status;
   assign rsp_ch.last        = out_item.last;

   // a job is never pushed into a full queue
   `PEP_ASSERT_IMP(a_no_overflow, clock, reset, push, !q_status.full)
   // a pushed job is waiting or in progress on the next cycle
   `PEP_ASSERT_NEXT(a_push_lands, clock, reset, push, !q_status.empty)
   // a status report always closes its command
   `PEP_ASSERT_IMP(a_status_last, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_STATUS, rsp_ch.last)
   // only bus write cycles carry data
   `PEP_ASSERT_IMP(a_data_on_write, clock, reset, rsp_ch.valid && rsp_ch.kind != KIND_WRITE, rsp_ch.bus_data == '0)

endmodule

`default_nettype wire

@@ hw/rtl/pep_queue.sv @@
// short job queue between the command front end and the bus back end
`default_nettype none

module pep_queue import pep_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire job_type          push_job,
   input  wire logic             pop,
   output job_type               head_job,
   output queue_status_type      q_status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // pointer wrap at the configured depth
   function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] n;
      if (p == IDX_W'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + IDX_W'(1);
      end
      return n;
   endfunction

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = slot_ff[rd_ptr_ff];

   // next pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pep_front.sv @@
// command front end: session, run and polling state, at most one job per command
`default_nettype none

module pep_front import pep_pkg::*; #(
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   pep_req_if.sink               req,
   input  wire cfg_type          cfg,
   input  wire queue_status_type q_status,
   output logic                  push,
   output job_type               push_job
);

   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_WRITE      = 6'b000010,
      PH_POLL       = 6'b000100,
      PH_VRUN       = 6'b001000,
      PH_VWAIT      = 6'b010000,
      PH_VWAIT_LAST = 6'b100000
   } phase_type;

   logic              session_ff, session_in;
   phase_type         phase_ff, phase_in;
   logic              have_first_ff, have_first_in;
   logic [ADDR_W-1:0] last_addr_ff, last_addr_in;
   logic [DATA_W-1:0] expect_last_ff, expect_last_in;
   logic [DATA_W-1:0] prev_poll_ff, prev_poll_in;
   logic [POLL_W-1:0] attempt_ff, attempt_in;
   logic [DATA_W-1:0] verify_exp_ff, verify_exp_in;

   logic                  accept;
   logic                  job_valid;
   job_type               job;
   logic [BUS_ADDR_W-1:0] run_end;
   logic                  crossed;
   logic [POLL_W:0]       poll_cnt;
   logic                  go;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && !q_status.full;
   assign push      = accept && job_valid;
   assign push_job  = job;

   // page check from first address and run length
   assign run_end  = {1'b0, req.address} + BUS_ADDR_W'(req.run_length) - BUS_ADDR_W'(1);
   assign crossed  = (({1'b0, req.address}) >> PAGE_SHIFT) != (run_end >> PAGE_SHIFT);
   assign poll_cnt = {1'b0, attempt_ff} + (POLL_W+1)'(1);

   // command decode and state update
   always_comb begin
      session_in     = session_ff;
      phase_in       = phase_ff;
      have_first_in  = have_first_ff;
      last_addr_in   = last_addr_ff;
      expect_last_in = expect_last_ff;
      prev_poll_in   = prev_poll_ff;
      attempt_in     = attempt_ff;
      verify_exp_in  = verify_exp_ff;
      job_valid      = 1'b0;
      job.kind       = JOB_STATUS;
      job.addr       = {cfg.select_a15, req.address};
      job.data       = req.data_byte;
      job.status     = ST_OK;
      go             = 1'b0;

      case (req.action)
         ACT_OPEN: begin
            session_in = 1'b1;
            phase_in   = PH_IDLE;
            job_valid  = 1'b1;
         end
         ACT_CLOSE: begin
            session_in = 1'b0;
            phase_in   = PH_IDLE;
            job_valid  = 1'b1;
         end
         ACT_ERASE: begin
            phase_in  = PH_IDLE;
            job_valid = 1'b1;
            if (!session_ff) begin
               job.status = ST_NO_SESSION;
            end else begin
               job.kind = JOB_ERASE;
               job.addr = {cfg.select_a15, {ADDR_W{1'b0}}};
            end
         end
         ACT_WRITE: begin
            go = (phase_ff == PH_WRITE);
            if (req.first_of_run) begin
               phase_in = PH_IDLE;
               go       = 1'b0;
               if (!session_ff) begin
                  job_valid  = 1'b1;
                  job.status = ST_NO_SESSION;
               end else if (req.run_length == '0) begin
                  job_valid = 1'b1;
               end else if (crossed) begin
                  job_valid  = 1'b1;
                  job.status = ST_PAGE;
               end else begin
                  go       = 1'b1;
                  phase_in = PH_WRITE;
               end
            end
            if (go) begin
               job_valid = 1'b1;
               job.kind  = JOB_WRITE;
               if (req.last_of_run) begin
                  job.kind       = JOB_WRITE_READ;
                  last_addr_in   = req.address;
                  expect_last_in = req.data_byte;
                  have_first_in  = 1'b0;
                  attempt_in     = '0;
                  phase_in       = PH_POLL;
               end
            end
         end
         ACT_VERIFY: begin
            go = (phase_ff == PH_VRUN);
            if (req.first_of_run) begin
               phase_in = PH_IDLE;
               go       = session_ff;
               if (!session_ff) begin
                  job_valid  = 1'b1;
                  job.status = ST_NO_SESSION;
               end
            end
            if (go) begin
               job_valid     = 1'b1;
               job.kind      = JOB_READ;
               verify_exp_in = req.data_byte;
               phase_in      = req.last_of_run ? PH_VWAIT_LAST : PH_VWAIT;
            end
         end
         ACT_RETURN: begin
            if (phase_ff == PH_POLL) begin
               job_valid = 1'b1;
               job.addr  = {cfg.select_a15, last_addr_ff};
               if (!have_first_ff) begin
                  prev_poll_in  = req.read_data;
                  have_first_in = 1'b1;
                  attempt_in    = '0;
                  if (cfg.max_poll == '0) begin
                     phase_in   = PH_IDLE;
                     job.status = ST_TIMEOUT;
                  end else begin
                     job.kind = JOB_READ;
                  end
               end else if (req.read_data == prev_poll_ff) begin
                  phase_in   = PH_IDLE;
                  job.status = (req.read_data == expect_last_ff) ? ST_OK : ST_POLL_MIS;
               end else begin
                  prev_poll_in = req.read_data;
                  attempt_in   = poll_cnt[POLL_W-1:0];
                  if (poll_cnt >= {1'b0, cfg.max_poll}) begin
                     phase_in   = PH_IDLE;
                     job.status = ST_TIMEOUT;
                  end else begin
                     job.kind = JOB_READ;
                  end
               end
            end else if (phase_ff == PH_VWAIT || phase_ff == PH_VWAIT_LAST) begin
               if (req.read_data != verify_exp_ff) begin
                  phase_in   = PH_IDLE;
                  job_valid  = 1'b1;
                  job.status = ST_VERIFY_MIS;
               end else if (phase_ff == PH_VWAIT_LAST) begin
                  phase_in  = PH_IDLE;
                  job_valid = 1'b1;
               end else begin
                  phase_in = PH_VRUN;
               end
            end
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff    <= 1'b0;
         phase_ff      <= PH_IDLE;
         have_first_ff <= 1'b0;
      end else if (accept) begin
         session_ff    <= session_in;
         phase_ff      <= phase_in;
         have_first_ff <= have_first_in;
      end
   end

   // run and poll payload
   always_ff @(posedge clock) begin
      if (accept) begin
         last_addr_ff   <= last_addr_in;
         expect_last_ff <= expect_last_in;
         prev_poll_ff   <= prev_poll_in;
         attempt_ff     <= attempt_in;
         verify_exp_ff  <= verify_exp_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pep_back.sv @@
// bus back end: expands each job into bus cycles and status reports
`default_nettype none

module pep_back import pep_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          head_job,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_item_type          rsp_item
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff;
   rsp_item_type      out_item_ff;
   rsp_item_type      item;
   logic              load;
   logic              emit;

   assign load      = !out_valid_ff || rsp_ready;
   assign emit      = load && !q_status.empty;
   assign pop       = emit && item.last;
   assign step_in   = pop ? '0 : (emit ? step_ff + STEP_W'(1) : step_ff);
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // item for the current step of the head job
   always_comb begin
      item.kind        = KIND_STATUS;
      item.bus_address = '0;
      item.bus_data    = '0;
      item.status      = ST_OK;
      item.last        = 1'b1;
      case (head_job.kind)
         JOB_STATUS: begin
            item.status = head_job.status;
         end
         JOB_READ: begin
            item.kind        = KIND_READ;
            item.bus_address = head_job.addr;
         end
         JOB_WRITE: begin
            item.kind        = KIND_WRITE;
            item.bus_address = head_job.addr;
            item.bus_data    = head_job.data;
         end
         JOB_WRITE_READ: begin
            item.bus_address = head_job.addr;
            if (step_ff == '0) begin
               item.kind     = KIND_WRITE;
               item.bus_data = head_job.data;
               item.last     = 1'b0;
            end else begin
               item.kind = KIND_READ;
            end
         end
         JOB_ERASE: begin
            if (step_ff < STEP_W'(UNLOCK_LEN)) begin
               item.kind        = KIND_WRITE;
               item.bus_address = {head_job.addr[BUS_ADDR_W-1], unlock_addr(step_ff)};
               item.bus_data    = unlock_data(step_ff);
               item.last        = 1'b0;
            end
         end
         default: begin
            item.status = head_job.status;
         end
      endcase
   end

   // step counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (load) begin
            out_valid_ff <= !q_status.empty;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit) begin
         out_item_ff <= item;
      end
   end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench for the parallel eeprom program sequencer: directed table, then random command runs
module testbench;
   import pep_pkg::*;

   localparam int PAGE_SHIFT       = PAGE_SHIFT_DEFAULT;
   localparam int DIRECTED_ROWS    = 25;
   localparam int PHASES           = 5;
   localparam int RANDOM_PER_PHASE = 16;
   localparam int SETTLE_CYCLES    = 10;
   localparam int STALL_LIMIT      = 1000;

   // action codes with no meaning to the block
   localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

   // chip erase unlock writes
   localparam logic [ADDR_W-1:0] ERASE_ADDR [UNLOCK_LEN] =
      '{15'h5555, 15'h2aaa, 15'h5555, 15'h5555, 15'h2aaa, 15'h5555};
   localparam logic [DATA_W-1:0] ERASE_DATA [UNLOCK_LEN] =
      '{8'haa, 8'h55, 8'h80, 8'haa, 8'h55, 8'h10};

   // per phase settings: poll limit, select level, sender idle and receiver stall odds
   localparam int PHASE_LIMIT [PHASES] = '{100000, 1, 0, 131071, 3};
   localparam int PHASE_A15   [PHASES] = '{0, 1, 0, 1, 0};
   localparam int PHASE_IDLE  [PHASES] = '{0, 65, 0, 17, 0};
   localparam int PHASE_STALL [PHASES] = '{0, 0, 65, 17, 0};

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   data_byte;
      logic [LEN_W-1:0]    run_length;
      logic                first_of_run;
      logic                last_of_run;
      logic [DATA_W-1:0]   read_data;
   } cmd_item_type;

   typedef struct packed {
      cmd_item_type cmd;
      logic         typed;
      status_type   want;
   } cmd_row_type;

   typedef enum logic [2:0] {
      RUN_IDLE, RUN_WRITE, RUN_POLL, RUN_VERIFY, RUN_VERIFY_WAIT, RUN_VERIFY_LAST
   } run_phase_type;

   logic clock;
   logic reset;

   pep_req_if req_ch ();
   pep_rsp_if rsp_ch ();
   pep_csr_if csr_ch ();

   parallel_eeprom_program_sequencer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // sequencer state as the testbench sees it
   logic              sess_open;
   run_phase_type     run_phase;
   logic [ADDR_W-1:0] poll_addr;
   logic [DATA_W-1:0] poll_target;
   logic [DATA_W-1:0] poll_prev;
   logic              poll_seen_first;
   logic [POLL_W-1:0] poll_tries;
   logic [DATA_W-1:0] verify_byte;
   logic [POLL_W-1:0] cfg_max_poll;
   logic              cfg_a15;

   rsp_item_type step_cycles [$];
   rsp_item_type expected_bus_cycles [$];

   int send_idle_pct;
   int stall_pct;
   int sent_items;
   int failures;
   int quiet_cycles;

   // directed commands; status typed in where it is plain from the command
   cmd_row_type directed_rows [DIRECTED_ROWS] = '{
      // out of session
      '{'{ACT_ERASE,    15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b1, ST_NO_SESSION},
      '{'{ACT_WRITE,    15'h0100, 8'h12, 7'd4,  1'b1, 1'b0, 8'h00}, 1'b1, ST_NO_SESSION},
      '{'{ACT_WRITE,    15'h0101, 8'h34, 7'd0,  1'b0, 1'b1, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_VERIFY,   15'h0100, 8'h12, 7'd0,  1'b1, 1'b1, 8'h00}, 1'b1, ST_NO_SESSION},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'hff}, 1'b0, ST_OK},
      '{'{ACT_UNUSED_6, 15'h7fff, 8'hff, 7'd64, 1'b1, 1'b1, 8'hff}, 1'b0, ST_OK},
      // session control, open while open
      '{'{ACT_CLOSE,    15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b1, ST_OK},
      '{'{ACT_OPEN,     15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b1, ST_OK},
      '{'{ACT_OPEN,     15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b1, ST_OK},
      '{'{ACT_ERASE,    15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b0, ST_OK},
      // zero length run, then a byte of it that is ignored
      '{'{ACT_WRITE,    15'h0040, 8'h99, 7'd0,  1'b1, 1'b0, 8'h00}, 1'b1, ST_OK},
      '{'{ACT_WRITE,    15'h0041, 8'h98, 7'd0,  1'b0, 1'b1, 8'h00}, 1'b0, ST_OK},
      // run crossing a page
      '{'{ACT_WRITE,    15'h003f, 8'h01, 7'd2,  1'b1, 1'b0, 8'h00}, 1'b1, ST_PAGE},
      // full page run at the top, cut short by last
      '{'{ACT_WRITE,    15'h7fc0, 8'hff, 7'd64, 1'b1, 1'b0, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_WRITE,    15'h7fff, 8'h00, 7'd0,  1'b0, 1'b1, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'ha5}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h00}, 1'b0, ST_OK},
      // one byte run settling on the wrong byte
      '{'{ACT_WRITE,    15'h0000, 8'h5a, 7'd1,  1'b1, 1'b1, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h11}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h11}, 1'b1, ST_POLL_MIS},
      // verify run failing on its last byte
      '{'{ACT_VERIFY,   15'h1234, 8'h77, 7'd0,  1'b1, 1'b0, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h77}, 1'b0, ST_OK},
      '{'{ACT_VERIFY,   15'h1235, 8'h88, 7'd0,  1'b0, 1'b1, 8'h00}, 1'b0, ST_OK},
      '{'{ACT_RETURN,   15'h0000, 8'h00, 7'd0,  1'b0, 1'b0, 8'h89}, 1'b1, ST_VERIFY_MIS}
   };

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic cmd_item_type make_cmd(input logic [ACTION_W-1:0] action,
                                             input logic [ADDR_W-1:0] address,
                                             input logic [DATA_W-1:0] data_byte,
                                             input logic [LEN_W-1:0] run_length,
                                             input logic first_of_run,
                                             input logic last_of_run,
                                             input logic [DATA_W-1:0] read_data);
      cmd_item_type c;
      c.action       = action;
      c.address      = address;
      c.data_byte    = data_byte;
      c.run_length   = run_length;
      c.first_of_run = first_of_run;
      c.last_of_run  = last_of_run;
      c.read_data    = read_data;
      return c;
   endfunction

   function automatic void push_cycle(input kind_type kind, input logic [ADDR_W-1:0] a,
                                      input logic [DATA_W-1:0] d);
      rsp_item_type r;
      r.kind        = kind;
      r.bus_address = {cfg_a15, a};
      r.bus_data    = d;
      r.status      = ST_OK;
      r.last        = 1'b0;
      step_cycles.push_back(r);
   endfunction

   function automatic void push_status(input status_type s);
      rsp_item_type r;
      r.kind        = KIND_STATUS;
      r.bus_address = '0;
      r.bus_data    = '0;
      r.status      = s;
      r.last        = 1'b0;
      step_cycles.push_back(r);
   endfunction

   // bus cycles and status reports caused by one command
   function automatic void predict_bus_cycles(input cmd_item_type c);
      int unsigned run_end;
      int unsigned tries;
      int i;
      step_cycles.delete();
      case (c.action)
         ACT_OPEN: begin
            sess_open = 1'b1;
            run_phase = RUN_IDLE;
            push_status(ST_OK);
         end
         ACT_CLOSE: begin
            sess_open = 1'b0;
            run_phase = RUN_IDLE;
            push_status(ST_OK);
         end
         ACT_ERASE: begin
            run_phase = RUN_IDLE;
            if (!sess_open) begin
               push_status(ST_NO_SESSION);
            end else begin
               for (i = 0; i < UNLOCK_LEN; i++) push_cycle(KIND_WRITE, ERASE_ADDR[i], ERASE_DATA[i]);
               push_status(ST_OK);
            end
         end
         ACT_WRITE: begin
            // first byte judges session, length and page
            if (c.first_of_run) begin
               run_end   = c.address + c.run_length - 1;
               run_phase = RUN_IDLE;
               if (!sess_open) push_status(ST_NO_SESSION);
               else if (c.run_length == 0) push_status(ST_OK);
               else if ((c.address >> PAGE_SHIFT) != (run_end >> PAGE_SHIFT)) push_status(ST_PAGE);
               else run_phase = RUN_WRITE;
            end
            if (run_phase == RUN_WRITE) begin
               push_cycle(KIND_WRITE, c.address, c.data_byte);
               if (c.last_of_run) begin
                  poll_addr       = c.address;
                  poll_target     = c.data_byte;
                  poll_seen_first = 1'b0;
                  poll_tries      = '0;
                  run_phase       = RUN_POLL;
                  push_cycle(KIND_READ, c.address, 8'h00);
               end
            end
         end
         ACT_VERIFY: begin
            if (c.first_of_run) begin
               run_phase = RUN_IDLE;
               if (!sess_open) push_status(ST_NO_SESSION);
               else run_phase = RUN_VERIFY;
            end
            if (run_phase == RUN_VERIFY) begin
               verify_byte = c.data_byte;
               run_phase   = c.last_of_run ? RUN_VERIFY_LAST : RUN_VERIFY_WAIT;
               push_cycle(KIND_READ, c.address, 8'h00);
            end
         end
         ACT_RETURN: begin
            if (run_phase == RUN_POLL) begin
               // data polling: done when two reads in a row agree
               if (!poll_seen_first) begin
                  poll_prev       = c.read_data;
                  poll_seen_first = 1'b1;
                  poll_tries      = '0;
                  if (cfg_max_poll == 0) begin
                     run_phase = RUN_IDLE;
                     push_status(ST_TIMEOUT);
                  end else begin
                     push_cycle(KIND_READ, poll_addr, 8'h00);
                  end
               end else begin
                  tries = poll_tries + 1;
                  if (c.read_data == poll_prev) begin
                     run_phase = RUN_IDLE;
                     push_status(c.read_data == poll_target ? ST_OK : ST_POLL_MIS);
                  end else begin
                     poll_prev  = c.read_data;
                     poll_tries = tries[POLL_W-1:0];
                     if (tries >= cfg_max_poll) begin
                        run_phase = RUN_IDLE;
                        push_status(ST_TIMEOUT);
                     end else begin
                        push_cycle(KIND_READ, poll_addr, 8'h00);
                     end
                  end
               end
            end else if (run_phase == RUN_VERIFY_WAIT || run_phase == RUN_VERIFY_LAST) begin
               if (c.read_data != verify_byte) begin
                  run_phase = RUN_IDLE;
                  push_status(ST_VERIFY_MIS);
               end else if (run_phase == RUN_VERIFY_LAST) begin
                  run_phase = RUN_IDLE;
                  push_status(ST_OK);
               end else begin
                  run_phase = RUN_VERIFY;
               end
            end
         end
         default: begin
         end
      endcase
      if (step_cycles.size() != 0) step_cycles[step_cycles.size()-1].last = 1'b1;
   endfunction

   // drive one command from a falling edge until its transfer, then predict it
   task automatic send_cmd(input cmd_item_type c, input logic typed = 1'b0,
                           input status_type want = ST_OK);
      rsp_item_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= c.action;
      req_ch.address      <= c.address;
      req_ch.data_byte    <= c.data_byte;
      req_ch.run_length   <= c.run_length;
      req_ch.first_of_run <= c.first_of_run;
      req_ch.last_of_run  <= c.last_of_run;
      req_ch.read_data    <= c.read_data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_bus_cycles(c);
      sent_items++;
      if (typed) begin
         r.kind        = KIND_STATUS;
         r.bus_address = '0;
         r.bus_data    = '0;
         r.status      = want;
         r.last        = 1'b1;
         expected_bus_cycles.push_back(r);
      end else begin
         foreach (step_cycles[i]) expected_bus_cycles.push_back(step_cycles[i]);
      end
      @(negedge clock);
   endtask

   // stop sending, wait for every expected result, then let the block go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_bus_cycles.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write both registers back to back while the block is idle
   task automatic write_config(input logic [POLL_W-1:0] limit, input logic a15);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_MAX_POLL;
      csr_ch.data  <= CSR_DATA_W'(limit);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      cfg_max_poll = limit;
      @(negedge clock);
      csr_ch.index <= CSR_SELECT_A15;
      csr_ch.data  <= CSR_DATA_W'(a15);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      cfg_a15 = a15;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // one random sequence: mostly well formed runs, some noise and broken runs
   task automatic random_sequence();
      int pick;
      int len;
      int off;
      int nbytes;
      int polls;
      int k;
      logic [ADDR_W-1:0] base;
      logic [DATA_W-1:0] d;
      logic [DATA_W-1:0] rd;
      logic drop_last;
      pick = $urandom_range(99);
      if (!sess_open && pick < 60) begin
         send_cmd(make_cmd(ACT_OPEN, 15'($urandom), 8'($urandom), 7'd0, 1'b0, 1'b0, 8'($urandom)));
      end else if (pick < 10) begin
         // noise: any action, any field
         send_cmd(make_cmd(3'($urandom_range(0, 7)), 15'($urandom), 8'($urandom),
                           7'($urandom_range(0, 64)), 1'($urandom), 1'($urandom), 8'($urandom)));
      end else if (pick < 18) begin
         send_cmd(make_cmd(ACT_ERASE, 15'($urandom), 8'($urandom), 7'd0, 1'b0, 1'b0, 8'h00));
      end else if (pick < 23) begin
         send_cmd(make_cmd(ACT_CLOSE, 15'($urandom), 8'($urandom), 7'd0, 1'b0, 1'b0, 8'h00));
      end else if (pick < 28) begin
         send_cmd(make_cmd(ACT_OPEN, 15'($urandom), 8'($urandom), 7'd0, 1'b0, 1'b0, 8'h00));
      end else if (pick < 65) begin
         // page write run, then data polling
         if ($urandom_range(99) < 8) len = 64;
         else if ($urandom_range(99) < 6) len = 0;
         else len = $urandom_range(1, 6);
         if (len == 64) off = 0;
         else if (len == 0) off = $urandom_range(0, 63);
         else off = $urandom_range(0, 64 - len);
         if ($urandom_range(99) < 15) base = 15'($urandom);
         else base = {9'($urandom), 6'(off)};
         nbytes = (len == 0 || len > 6) ? $urandom_range(1, 6) : len;
         if ($urandom_range(99) < 12) nbytes = $urandom_range(1, nbytes);
         drop_last = ($urandom_range(99) < 6);
         for (k = 0; k < nbytes; k++) begin
            send_cmd(make_cmd(ACT_WRITE, 15'(base + k), 8'($urandom), 7'(len), k == 0,
                              (k == nbytes - 1) && !drop_last, 8'($urandom)));
         end
         polls = 0;
         if ($urandom_range(99) < 8) polls = 8;
         while (run_phase == RUN_POLL && polls < 8) begin
            if (!poll_seen_first) rd = ($urandom_range(99) < 50) ? poll_target : 8'($urandom);
            else if ($urandom_range(99) < 55) rd = poll_prev;
            else rd = ($urandom_range(99) < 50) ? poll_target : 8'($urandom);
            send_cmd(make_cmd(ACT_RETURN, 15'($urandom), 8'($urandom), 7'($urandom_range(0, 64)),
                              1'b0, 1'b0, rd));
            polls++;
         end
      end else begin
         // verify run, most bytes answered by a read return
         nbytes = $urandom_range(1, 4);
         base   = 15'($urandom);
         for (k = 0; k < nbytes; k++) begin
            d = 8'($urandom);
            send_cmd(make_cmd(ACT_VERIFY, 15'(base + k), d, 7'($urandom_range(0, 64)), k == 0,
                              k == nbytes - 1, 8'($urandom)));
            if (run_phase != RUN_VERIFY_WAIT && run_phase != RUN_VERIFY_LAST) break;
            if ($urandom_range(99) < 5) continue;
            rd = ($urandom_range(99) < 85) ? d : d ^ 8'($urandom_range(1, 255));
            send_cmd(make_cmd(ACT_RETURN, 15'($urandom), 8'($urandom), 7'd0, 1'b0, 1'b0, rd));
            if (run_phase == RUN_IDLE) break;
         end
      end
   endtask

   // result receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bus_cycles.size() == 0) begin
            $error("result with none expected: kind %0d address %0h data %0h status %0d",
                   rsp_ch.kind, rsp_ch.bus_address, rsp_ch.bus_data, rsp_ch.status);
            failures++;
         end else begin
            want = expected_bus_cycles.pop_front();
            if (rsp_ch.kind != want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
               failures++;
            end
            if (rsp_ch.bus_address != want.bus_address) begin
               $error("bus_address: expected %0h, actual %0h", want.bus_address,
                      rsp_ch.bus_address);
               failures++;
            end
            if (rsp_ch.bus_data != want.bus_data) begin
               $error("bus_data: expected %0h, actual %0h", want.bus_data, rsp_ch.bus_data);
               failures++;
            end
            if (rsp_ch.status != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               failures++;
            end
            if (rsp_ch.last != want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // reset, directed table, then random phases with new settings each
   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = '0;
      req_ch.address      = '0;
      req_ch.data_byte    = '0;
      req_ch.run_length   = '0;
      req_ch.first_of_run = 1'b0;
      req_ch.last_of_run  = 1'b0;
      req_ch.read_data    = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      quiet_cycles        = 0;
      failures            = 0;
      sent_items          = 0;
      send_idle_pct       = PHASE_IDLE[0];
      stall_pct           = PHASE_STALL[0];
      sess_open           = 1'b0;
      run_phase           = RUN_IDLE;
      poll_addr           = '0;
      poll_target         = '0;
      poll_prev           = '0;
      poll_seen_first     = 1'b0;
      poll_tries          = '0;
      verify_byte         = '0;
      cfg_max_poll        = POLL_LIMIT_RESET;
      cfg_a15             = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            settle();
            write_config(POLL_W'(PHASE_LIMIT[p]), 1'(PHASE_A15[p]));
         end
         send_idle_pct = PHASE_IDLE[p];
         stall_pct     = PHASE_STALL[p];
         sent_items    = 0;
         while (sent_items < RANDOM_PER_PHASE) random_sequence();
      end

      settle();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
